### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, used by jse_serialize
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: property does not hold");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

`endif

### design/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// types, character codes and helpers shared by the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

	typedef logic [7:0] byte_t;

	// longest escape run and the width of its length and index
	localparam int RUN_MAX   = 6;
	localparam int RUN_LEN_W = 3;

	typedef logic [RUN_LEN_W-1:0] run_len_t;

	localparam run_len_t RUN_PLAIN   = 3'd1;
	localparam run_len_t RUN_PAIR    = 3'd2;
	localparam run_len_t RUN_UNICODE = 3'd6;

	// characters used in escapes
	localparam byte_t CH_BACKSLASH = 8'h5C;
	localparam byte_t CH_QUOTE     = 8'h22;
	localparam byte_t CH_U         = 8'h75;
	localparam byte_t CH_ZERO      = 8'h30;
	localparam byte_t CH_LOWER_A   = 8'h61;
	localparam byte_t CH_B         = 8'h62;
	localparam byte_t CH_F         = 8'h66;
	localparam byte_t CH_N         = 8'h6E;
	localparam byte_t CH_R         = 8'h72;
	localparam byte_t CH_T         = 8'h74;

	// control codes with a short escape
	localparam byte_t CODE_BS  = 8'h08;
	localparam byte_t CODE_TAB = 8'h09;
	localparam byte_t CODE_LF  = 8'h0A;
	localparam byte_t CODE_FF  = 8'h0C;
	localparam byte_t CODE_CR  = 8'h0D;

	// highest control code
	localparam byte_t CTRL_MAX = 8'h1F;

	// nibble values from here on print as letters
	localparam logic [3:0] NIBBLE_DEC_LIMIT = 4'd10;

	typedef enum logic [1:0] {
		ESC_PLAIN,
		ESC_PAIR,
		ESC_UNICODE
	} esc_class_t;

	// stage 1 payload: raw byte classified
	typedef struct packed {
		byte_t      raw;
		logic       fin;
		esc_class_t cls;
		byte_t      esc_char;
	} cls_beat_t;

	// stage 2 payload: complete escape run
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] seq;
		run_len_t                len;
		logic                    fin;
	} run_beat_t;

	// lowercase hex digit for one nibble
	function automatic byte_t nibble_char(input logic [3:0] n);
		byte_t ext;
		ext = {4'h0, n};
		if (n < NIBBLE_DEC_LIMIT) begin
			return ext + CH_ZERO;
		end
		return ext - {4'h0, NIBBLE_DEC_LIMIT} + CH_LOWER_A;
	endfunction

endpackage

### design/jse_raw_if.sv
// ----------------------------------------------------------------------------
// jse_raw_if
// channel of raw string bytes into the escaper
// ----------------------------------------------------------------------------
interface jse_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

### design/jse_esc_if.sv
// ----------------------------------------------------------------------------
// jse_esc_if
// channel of escaped text bytes out of the escaper
// ----------------------------------------------------------------------------
interface jse_esc_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;

	modport source (output valid, output out_byte, output run_last,
		output string_done, input ready);
	modport sink (input valid, input out_byte, input run_last,
		input string_done, output ready);
endinterface

### design/jse_classify.sv
// ----------------------------------------------------------------------------
// jse_classify
// stage 1: registers each raw beat with its escape class and escape letter
// ----------------------------------------------------------------------------
module jse_classify import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	jse_raw_if.sink    raw,
	output logic       valid_s1,
	output cls_beat_t  beat_s1,
	input  logic       ready_s2
);

	cls_beat_t beat_d;

	// stage advances when empty or when stage 2 takes it
	assign raw.ready = !valid_s1 || ready_s2;

	// classify the raw byte
	always_comb begin
		beat_d.raw      = raw.in_byte;
		beat_d.fin      = raw.string_end;
		beat_d.cls      = ESC_PLAIN;
		beat_d.esc_char = raw.in_byte;
		unique case (raw.in_byte)
			CH_QUOTE, CH_BACKSLASH: begin
				beat_d.cls = ESC_PAIR;
			end
			CODE_BS: begin
				beat_d.cls      = ESC_PAIR;
				beat_d.esc_char = CH_B;
			end
			CODE_FF: begin
				beat_d.cls      = ESC_PAIR;
				beat_d.esc_char = CH_F;
			end
			CODE_LF: begin
				beat_d.cls      = ESC_PAIR;
				beat_d.esc_char = CH_N;
			end
			CODE_CR: begin
				beat_d.cls      = ESC_PAIR;
				beat_d.esc_char = CH_R;
			end
			CODE_TAB: begin
				beat_d.cls      = ESC_PAIR;
				beat_d.esc_char = CH_T;
			end
			default: begin
				if (raw.in_byte <= CTRL_MAX) begin
					beat_d.cls = ESC_UNICODE;
				end
			end
		endcase
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			beat_s1 <= beat_d;
		end
	end

endmodule

### design/jse_expand.sv
// ----------------------------------------------------------------------------
// jse_expand
// stage 2: builds the full escape run and its length from the class
// ----------------------------------------------------------------------------
module jse_expand import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  cls_beat_t  beat_s1,
	output logic       ready_s2,
	output logic       valid_s2,
	output run_beat_t  beat_s2,
	input  logic       ready_s3
);

	run_beat_t beat_d;

	assign ready_s2 = !valid_s2 || ready_s3;

	// lay out the run bytes
	always_comb begin
		beat_d.seq = '0;
		beat_d.fin = beat_s1.fin;
		beat_d.len = RUN_PLAIN;
		unique case (beat_s1.cls)
			ESC_PLAIN: begin
				beat_d.seq[0] = beat_s1.raw;
				beat_d.len    = RUN_PLAIN;
			end
			ESC_PAIR: begin
				beat_d.seq[0] = CH_BACKSLASH;
				beat_d.seq[1] = beat_s1.esc_char;
				beat_d.len    = RUN_PAIR;
			end
			ESC_UNICODE: begin
				beat_d.seq[0] = CH_BACKSLASH;
				beat_d.seq[1] = CH_U;
				beat_d.seq[2] = CH_ZERO;
				beat_d.seq[3] = CH_ZERO;
				beat_d.seq[4] = nibble_char(beat_s1.raw[7:4]);
				beat_d.seq[5] = nibble_char(beat_s1.raw[3:0]);
				beat_d.len    = RUN_UNICODE;
			end
			default: begin
				beat_d.seq[0] = beat_s1.raw;
				beat_d.len    = RUN_PLAIN;
			end
		endcase
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			beat_s2 <= beat_d;
		end
	end

endmodule

### design/jse_serialize.sv
// ----------------------------------------------------------------------------
// jse_serialize
// stage 3 holds one run and walks it; output register drives the text beats
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jse_serialize import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  run_beat_t  beat_s2,
	output logic       ready_s3,
	jse_esc_if.source  esc
);

	logic       valid_s3;
	run_beat_t  beat_s3;
	run_len_t   idx_q;
	logic       out_valid_q;
	byte_t      out_byte_q;
	logic       run_last_q;
	logic       string_done_q;
	logic       last_byte;
	logic       out_load;

	// current byte is the end of the held run
	assign last_byte = (idx_q == (beat_s3.len - RUN_PLAIN));
	assign out_load  = valid_s3 && (!out_valid_q || esc.ready);
	assign ready_s3  = !valid_s3 || (out_load && last_byte);

	// run hold and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			idx_q    <= '0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
			idx_q    <= '0;
		end else if (out_load) begin
			idx_q <= idx_q + RUN_PLAIN;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			beat_s3 <= beat_s2;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (esc.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q    <= beat_s3.seq[idx_q];
			run_last_q    <= last_byte;
			string_done_q <= last_byte && beat_s3.fin;
		end
	end

	assign esc.valid       = out_valid_q;
	assign esc.out_byte    = out_byte_q;
	assign esc.run_last    = run_last_q;
	assign esc.string_done = string_done_q;

	// index stays inside the held run
	`ASSERT_PROP(a_idx_in_run, clk, arst_n, valid_s3 |-> (idx_q < beat_s3.len))
	// end of string only on the end of a run
	`ASSERT_PROP(a_done_on_last, clk, arst_n, (esc.valid && esc.string_done) |-> esc.run_last)
	// a run in progress keeps the output fed
	`ASSERT_PROP(a_run_continues, clk, arst_n,
		(esc.valid && esc.ready && !esc.run_last) |=> esc.valid)
	// index only moves off zero while a run is held
	`ASSERT_NEVER(a_idx_without_run, clk, arst_n, !valid_s3 && (idx_q != '0))

endmodule

### design/json_string_escaper_top.sv
// ----------------------------------------------------------------------------
// json_string_escaper_top
// raw beats pass the s1, s2, s3 and output registers on the way to the text
// throughput: one raw beat per cycle with plain bytes and esc.ready held high
// an escaped byte holds the run serializer for its 2 or 6 text beats
// reset: arst_n clears all valid bits at once; pipeline comes up empty
// ----------------------------------------------------------------------------
module json_string_escaper_top import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	jse_raw_if.sink    raw,
	jse_esc_if.source  esc
);

	logic      valid_s1;
	cls_beat_t beat_s1;
	logic      ready_s2;
	logic      valid_s2;
	run_beat_t beat_s2;
	logic      ready_s3;

	// classify stage
	jse_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.ready_s2 (ready_s2)
	);

	// run build stage
	jse_expand u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.ready_s2 (ready_s2),
		.valid_s2 (valid_s2),
		.beat_s2  (beat_s2),
		.ready_s3 (ready_s3)
	);

	// run walk and output register
	jse_serialize u_serialize (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.beat_s2  (beat_s2),
		.ready_s3 (ready_s3),
		.esc      (esc)
	);

endmodule

### tb/sv/tb_json_string_escaper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_top
// self-checking bench for the json string escaper: a directed table of raw
// bytes, then random strings, each raw beat turned into its expected escaped
// text and every text beat compared field by field, in order, under random
// sender bursts, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_json_string_escaper_top;
	import jse_pkg::*;

	// rows that carry no typed-in text are checked against the escape predictor
	localparam run_len_t RUN_PREDICT = 3'd0;
	localparam int DIR_ROWS     = 22;
	localparam int RAND_ITEMS   = 448;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AFTER   = 60;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX   = 50;

	typedef struct packed {
		byte_t       raw;
		logic        fin;
		run_len_t    exp_len;
		logic [47:0] exp_text;
	} raw_item_t;

	typedef struct packed {
		byte_t ch;
		logic  run_last;
		logic  done;
	} text_beat_t;

	// directed table: extremes, every escape kind, string ends on each kind
	localparam raw_item_t DIR_TABLE [DIR_ROWS] = '{
		'{8'h41,        1'b0, RUN_PLAIN,   "A"},
		'{8'h00,        1'b0, RUN_UNICODE, "\\u0000"},
		'{8'hFF,        1'b0, RUN_PLAIN,   48'hFF},
		'{CTRL_MAX,     1'b1, RUN_UNICODE, "\\u001f"},
		'{CH_QUOTE,     1'b0, RUN_PAIR,    "\\\""},
		'{CH_BACKSLASH, 1'b0, RUN_PAIR,    "\\\\"},
		'{CODE_BS,      1'b0, RUN_PREDICT, 48'h0},
		'{CODE_FF,      1'b0, RUN_PREDICT, 48'h0},
		'{CODE_LF,      1'b0, RUN_PREDICT, 48'h0},
		'{CODE_CR,      1'b0, RUN_PREDICT, 48'h0},
		'{CODE_TAB,     1'b1, RUN_PREDICT, 48'h0},
		'{8'h0B,        1'b1, RUN_PREDICT, 48'h0},
		'{8'h20,        1'b0, RUN_PREDICT, 48'h0},
		'{8'h7F,        1'b0, RUN_PREDICT, 48'h0},
		'{8'h80,        1'b0, RUN_PREDICT, 48'h0},
		'{8'h10,        1'b0, RUN_PREDICT, 48'h0},
		'{8'h1A,        1'b1, RUN_PREDICT, 48'h0},
		'{CH_QUOTE,     1'b1, RUN_PREDICT, 48'h0},
		'{8'hFF,        1'b1, RUN_PREDICT, 48'h0},
		'{8'h00,        1'b1, RUN_PREDICT, 48'h0},
		'{8'h01,        1'b0, RUN_PREDICT, 48'h0},
		'{8'h5B,        1'b1, RUN_PREDICT, 48'h0}
	};

	logic clk;
	logic arst_n;

	jse_raw_if raw_bus ();
	jse_esc_if esc_bus ();

	json_string_escaper_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_bus),
		.esc    (esc_bus)
	);

	raw_item_t  string_bytes_q [$];
	text_beat_t expected_text_q [$];
	int         mismatch_count = 0;
	int         raw_accepted = 0;
	bit         all_sent = 1'b0;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < REPORT_MAX) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// lowercase hex digit of one nibble
	function automatic byte_t hex_digit(input logic [3:0] n);
		if (n < NIBBLE_DEC_LIMIT) begin
			return CH_ZERO + byte_t'(n);
		end
		return CH_LOWER_A + byte_t'(n) - byte_t'(NIBBLE_DEC_LIMIT);
	endfunction

	// escaped text of one raw byte, appended to the expected text
	function automatic void escape_byte(input byte_t b, input logic fin);
		byte_t seq [RUN_MAX];
		int    len;
		text_beat_t beat;
		len = 2;
		seq[0] = CH_BACKSLASH;
		case (b)
			CH_QUOTE:     seq[1] = CH_QUOTE;
			CH_BACKSLASH: seq[1] = CH_BACKSLASH;
			CODE_BS:      seq[1] = CH_B;
			CODE_FF:      seq[1] = CH_F;
			CODE_LF:      seq[1] = CH_N;
			CODE_CR:      seq[1] = CH_R;
			CODE_TAB:     seq[1] = CH_T;
			default: begin
				if (b <= CTRL_MAX) begin
					seq[1] = CH_U;
					seq[2] = CH_ZERO;
					seq[3] = CH_ZERO;
					seq[4] = hex_digit(b[7:4]);
					seq[5] = hex_digit(b[3:0]);
					len = 6;
				end else begin
					seq[0] = b;
					len = 1;
				end
			end
		endcase
		for (int k = 0; k < len; k++) begin
			beat.ch       = seq[k];
			beat.run_last = (k == len - 1);
			beat.done     = (k == len - 1) && fin;
			expected_text_q.insert(expected_text_q.size(), beat);
		end
	endfunction

	// typed-in text from the table, first character in the top byte
	function automatic void queue_typed_text(input raw_item_t item);
		text_beat_t beat;
		int len;
		len = int'(item.exp_len);
		for (int k = 0; k < len; k++) begin
			beat.ch       = item.exp_text[8*(len-1-k) +: 8];
			beat.run_last = (k == len - 1);
			beat.done     = (k == len - 1) && item.fin;
			expected_text_q.insert(expected_text_q.size(), beat);
		end
	endfunction

	// random string content, weighted toward escapes
	function automatic byte_t pick_string_byte();
		byte_t short_esc [7];
		int sel;
		short_esc = '{CH_QUOTE, CH_BACKSLASH, CODE_BS, CODE_FF, CODE_LF, CODE_CR, CODE_TAB};
		sel = $urandom_range(99, 0);
		if (sel < 45) begin
			return byte_t'($urandom_range(8'h7E, 8'h20));
		end
		if (sel < 60) begin
			return short_esc[$urandom_range(6, 0)];
		end
		if (sel < 75) begin
			return byte_t'($urandom_range(CTRL_MAX, 0));
		end
		return byte_t'($urandom_range(255, 0));
	endfunction

	// sender: table rows, then random strings, in bursts with gaps
	initial begin
		raw_item_t item;
		int len;
		int idx;
		int burst_left;
		int gap_left;
		raw_bus.valid      = 1'b0;
		raw_bus.in_byte    = '0;
		raw_bus.string_end = 1'b0;
		for (int r = 0; r < DIR_ROWS; r++) begin
			string_bytes_q.insert(string_bytes_q.size(), DIR_TABLE[r]);
		end
		while (string_bytes_q.size() < DIR_ROWS + RAND_ITEMS) begin
			len = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(12, 1);
			for (int k = 0; k < len; k++) begin
				item.raw      = pick_string_byte();
				item.fin      = (k == len - 1);
				item.exp_len  = RUN_PREDICT;
				item.exp_text = '0;
				string_bytes_q.insert(string_bytes_q.size(), item);
			end
		end
		wait (arst_n === 1'b1);
		idx = 0;
		burst_left = $urandom_range(20, 1);
		gap_left = 0;
		while (idx < string_bytes_q.size()) begin
			@(negedge clk);
			if (gap_left > 0) begin
				raw_bus.valid   <= 1'b0;
				raw_bus.in_byte <= byte_t'($urandom_range(255, 0));
				gap_left--;
			end else begin
				raw_bus.valid      <= 1'b1;
				raw_bus.in_byte    <= string_bytes_q[idx].raw;
				raw_bus.string_end <= string_bytes_q[idx].fin;
			end
			@(posedge clk);
			if (raw_bus.valid && raw_bus.ready) begin
				item = string_bytes_q[idx];
				if (item.exp_len == RUN_PREDICT) begin
					escape_byte(item.raw, item.fin);
				end else begin
					queue_typed_text(item);
				end
				idx++;
				raw_accepted++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(20, 1);
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 1);
				end
			end
		end
		@(negedge clk);
		raw_bus.valid <= 1'b0;
		all_sent = 1'b1;
	end

	// receiver: stretches of full, random and sparse ready, one long hold-off
	initial begin
		int mode;
		int stretch;
		int nth;
		bit hold_done;
		esc_bus.ready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && raw_accepted >= HOLD_AFTER) begin
				for (int c = 0; c < HOLD_CYCLES; c++) begin
					@(negedge clk);
					esc_bus.ready <= 1'b0;
				end
				hold_done = 1'b1;
			end
			mode = $urandom_range(2, 0);
			stretch = $urandom_range(60, 10);
			nth = $urandom_range(4, 2);
			for (int c = 0; c < stretch; c++) begin
				@(negedge clk);
				case (mode)
					0:       esc_bus.ready <= 1'b1;
					1:       esc_bus.ready <= 1'($urandom_range(1, 0));
					default: esc_bus.ready <= (c % nth) == 0;
				endcase
			end
		end
	end

	// text beat check against the oldest expectation
	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n && esc_bus.valid && esc_bus.ready) begin
			if (expected_text_q.size() == 0) begin
				report_mismatch($sformatf("text beat %h with nothing expected",
					esc_bus.out_byte));
			end else begin
				want = expected_text_q.pop_front();
				if (esc_bus.out_byte !== want.ch) begin
					report_mismatch($sformatf("out_byte got %h want %h",
						esc_bus.out_byte, want.ch));
				end
				if (esc_bus.run_last !== want.run_last) begin
					report_mismatch($sformatf("run_last got %b want %b on byte %h",
						esc_bus.run_last, want.run_last, want.ch));
				end
				if (esc_bus.string_done !== want.done) begin
					report_mismatch($sformatf("string_done got %b want %b on byte %h",
						esc_bus.string_done, want.done, want.ch));
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((raw_bus.valid && raw_bus.ready) || (esc_bus.valid && esc_bus.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d text beats outstanding",
					quiet, expected_text_q.size());
				$display("tb_json_string_escaper_top: FAIL");
				$finish;
			end
		end
	end

	// end of run once all text has arrived and the pipeline has drained
	initial begin
		wait (arst_n === 1'b1);
		@(negedge clk);
		while (!(all_sent && expected_text_q.size() == 0)) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_text_q.size() != 0) begin
			report_mismatch($sformatf("%0d text beats never arrived",
				expected_text_q.size()));
		end
		if (mismatch_count == 0) begin
			$display("tb_json_string_escaper_top: PASS");
		end else begin
			$display("tb_json_string_escaper_top: FAIL");
		end
		$finish;
	end

endmodule

### files.f
+incdir+design
design/jse_pkg.sv
design/jse_raw_if.sv
design/jse_esc_if.sv
design/jse_classify.sv
design/jse_expand.sv
design/jse_serialize.sv
design/json_string_escaper_top.sv
tb/sv/tb_json_string_escaper_top.sv
